// ===== rtl/cau_pkg.sv =====
// complex arithmetic unit: shared widths, operation codes and sideband type
// used by every module of the unit; depends on nothing
package cau_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = 8;

   // exact product, sum of two products and magnitude widths
   localparam int PROD_W = 2 * DATA_WIDTH;
   localparam int SUM_W  = PROD_W + 1;
   localparam int MAG_W  = PROD_W;
   // divider remainder and compare widths
   localparam int REM_W  = MAG_W + FRAC_BITS;
   localparam int CMP_W  = REM_W + DATA_WIDTH;
   localparam int DIV_STAGES = DATA_WIDTH;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic signed [SUM_W-1:0] SUM_MAX =
      SUM_W'((longint'(1) <<< (DATA_WIDTH - 1)) - longint'(1));
   localparam logic signed [SUM_W-1:0] SUM_MIN =
      SUM_W'(-(longint'(1) <<< (DATA_WIDTH - 1)));
   localparam logic [DATA_WIDTH-1:0] NEG_MAG = DATA_WIDTH'(1) << (DATA_WIDTH - 1);
   localparam logic [DATA_WIDTH-1:0] POS_MAG = NEG_MAG - DATA_WIDTH'(1);

   // results that travel beside the divider
   typedef struct packed {
      logic                         is_div;
      logic                         dz;
      logic                         neg_re;
      logic                         neg_im;
      logic                         sat;
      logic signed [DATA_WIDTH-1:0] res_re;
      logic signed [DATA_WIDTH-1:0] res_im;
   } side_type;

   function automatic logic signed [DATA_WIDTH-1:0] clip(
         input logic signed [SUM_W-1:0] v);
      logic signed [DATA_WIDTH-1:0] r;
      if (v > SUM_MAX) begin
         r = $signed(SUM_MAX[DATA_WIDTH-1:0]);
      end else if (v < SUM_MIN) begin
         r = $signed(SUM_MIN[DATA_WIDTH-1:0]);
      end else begin
         r = $signed(v[DATA_WIDTH-1:0]);
      end
      return r;
   endfunction

   function automatic logic clip_hit(input logic signed [SUM_W-1:0] v);
      return (v > SUM_MAX) || (v < SUM_MIN);
   endfunction

endpackage

// ===== rtl/cau_front.sv =====
// complex arithmetic unit front end: product stage and sum/saturate stage
// depends on cau_pkg
module cau_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  adv,
   input  logic                                  in_valid,
   input  logic [1:0]                            in_op,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_a_im,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] in_b_im,
   output logic                                  out_valid,
   output logic [cau_pkg::MAG_W-1:0]             out_num_re,
   output logic [cau_pkg::MAG_W-1:0]             out_num_im,
   output logic [cau_pkg::MAG_W-1:0]             out_den,
   output cau_pkg::side_type                     out_side
);

   localparam int W = cau_pkg::DATA_WIDTH;
   localparam int P = cau_pkg::PROD_W;

   // stage one registers
   logic                                s1_valid_ff;
   logic [1:0]                          op_ff;
   logic signed [cau_pkg::PROD_W-1:0]   p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [cau_pkg::PROD_W-1:0]   sq_r_ff, sq_i_ff;
   logic signed [W:0]                   as_re_ff, as_im_ff;
   logic signed [W:0]                   as_re_in, as_im_in;

   // stage two registers
   logic                                s2_valid_ff;
   logic [cau_pkg::MAG_W-1:0]           num_re_ff, num_im_ff, den_ff;
   cau_pkg::side_type                   side_ff;
   logic [cau_pkg::MAG_W-1:0]           num_re_in, num_im_in, den_in;
   cau_pkg::side_type                   side_in;

   // add or subtract per part, one bit wider
   always_comb begin
      if (in_op == cau_pkg::OP_SUB) begin
         as_re_in = (W+1)'(in_a_re) - (W+1)'(in_b_re);
         as_im_in = (W+1)'(in_a_im) - (W+1)'(in_b_im);
      end else begin
         as_re_in = (W+1)'(in_a_re) + (W+1)'(in_b_re);
         as_im_in = (W+1)'(in_a_im) + (W+1)'(in_b_im);
      end
   end

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= in_valid;
      end
      if (adv) begin
         op_ff    <= in_op;
         p_rr_ff  <= P'(in_a_re) * P'(in_b_re);
         p_ii_ff  <= P'(in_a_im) * P'(in_b_im);
         p_ri_ff  <= P'(in_a_re) * P'(in_b_im);
         p_ir_ff  <= P'(in_a_im) * P'(in_b_re);
         sq_r_ff  <= P'(in_b_re) * P'(in_b_re);
         sq_i_ff  <= P'(in_b_im) * P'(in_b_im);
         as_re_ff <= as_re_in;
         as_im_ff <= as_im_in;
      end
   end

   // sums of products, saturation, divide numerators and denominator
   always_comb begin
      logic signed [cau_pkg::SUM_W-1:0] m_re, m_im, n_re, n_im, a_re, a_im;
      m_re = (cau_pkg::SUM_W'(p_rr_ff) - cau_pkg::SUM_W'(p_ii_ff)) >>> cau_pkg::FRAC_BITS;
      m_im = (cau_pkg::SUM_W'(p_ri_ff) + cau_pkg::SUM_W'(p_ir_ff)) >>> cau_pkg::FRAC_BITS;
      n_re = cau_pkg::SUM_W'(p_rr_ff) + cau_pkg::SUM_W'(p_ii_ff);
      n_im = cau_pkg::SUM_W'(p_ir_ff) - cau_pkg::SUM_W'(p_ri_ff);
      a_re = cau_pkg::SUM_W'(as_re_ff);
      a_im = cau_pkg::SUM_W'(as_im_ff);
      den_in = $unsigned(sq_r_ff) + $unsigned(sq_i_ff);
      num_re_in = n_re[cau_pkg::SUM_W-1] ? cau_pkg::MAG_W'(-n_re) : cau_pkg::MAG_W'(n_re);
      num_im_in = n_im[cau_pkg::SUM_W-1] ? cau_pkg::MAG_W'(-n_im) : cau_pkg::MAG_W'(n_im);
      side_in.is_div = (op_ff == cau_pkg::OP_DIV);
      side_in.dz     = (op_ff == cau_pkg::OP_DIV) && (den_in == '0);
      side_in.neg_re = n_re[cau_pkg::SUM_W-1];
      side_in.neg_im = n_im[cau_pkg::SUM_W-1];
      if (op_ff == cau_pkg::OP_MUL) begin
         side_in.res_re = cau_pkg::clip(m_re);
         side_in.res_im = cau_pkg::clip(m_im);
         side_in.sat    = cau_pkg::clip_hit(m_re) | cau_pkg::clip_hit(m_im);
      end else begin
         side_in.res_re = cau_pkg::clip(a_re);
         side_in.res_im = cau_pkg::clip(a_im);
         side_in.sat    = cau_pkg::clip_hit(a_re) | cau_pkg::clip_hit(a_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         num_re_ff <= num_re_in;
         num_im_ff <= num_im_in;
         den_ff    <= den_in;
         side_ff   <= side_in;
      end
   end

   assign out_valid  = s2_valid_ff;
   assign out_num_re = num_re_ff;
   assign out_num_im = num_im_ff;
   assign out_den    = den_ff;
   assign out_side   = side_ff;

endmodule

// ===== rtl/cau_div.sv =====
// complex arithmetic unit divider: overflow check, then one quotient bit
// per stage for both parts; depends on cau_pkg
module cau_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              adv,
   input  logic                              in_valid,
   input  logic [cau_pkg::MAG_W-1:0]         in_num_re,
   input  logic [cau_pkg::MAG_W-1:0]         in_num_im,
   input  logic [cau_pkg::MAG_W-1:0]         in_den,
   input  cau_pkg::side_type                 in_side,
   output logic                              out_valid,
   output logic [cau_pkg::DATA_WIDTH-1:0]    out_q_re,
   output logic [cau_pkg::DATA_WIDTH-1:0]    out_q_im,
   output logic                              out_ovf_re,
   output logic                              out_ovf_im,
   output cau_pkg::side_type                 out_side
);

   localparam int W  = cau_pkg::DATA_WIDTH;
   localparam int NS = cau_pkg::DIV_STAGES;
   localparam int RW = cau_pkg::REM_W;
   localparam int CW = cau_pkg::CMP_W;

   logic                      valid_ff  [NS+1];
   logic [RW-1:0]             rem_re_ff [NS+1];
   logic [RW-1:0]             rem_im_ff [NS+1];
   logic [W-1:0]              q_re_ff   [NS+1];
   logic [W-1:0]              q_im_ff   [NS+1];
   logic [cau_pkg::MAG_W-1:0] den_ff    [NS+1];
   logic                      ovf_re_ff [NS+1];
   logic                      ovf_im_ff [NS+1];
   cau_pkg::side_type         side_ff   [NS+1];

   logic [RW-1:0]             rem_re_in [NS];
   logic [RW-1:0]             rem_im_in [NS];
   logic [W-1:0]              q_re_in   [NS];
   logic [W-1:0]              q_im_in   [NS];

   logic [RW-1:0]             n_re_sh, n_im_sh;
   logic [CW-1:0]             den_top;

   // numerators scaled by the fraction bits; quotient overflow check
   assign n_re_sh = {in_num_re, {cau_pkg::FRAC_BITS{1'b0}}};
   assign n_im_sh = {in_num_im, {cau_pkg::FRAC_BITS{1'b0}}};
   assign den_top = CW'(in_den) << W;

   // restoring step per stage, highest quotient bit first
   always_comb begin
      for (int k = 0; k < NS; k++) begin
         logic [CW-1:0] dsh;
         dsh = CW'(den_ff[k]) << (W - 1 - k);
         q_re_in[k] = q_re_ff[k];
         q_im_in[k] = q_im_ff[k];
         if (CW'(rem_re_ff[k]) >= dsh) begin
            rem_re_in[k] = RW'(CW'(rem_re_ff[k]) - dsh);
            q_re_in[k][W-1-k] = 1'b1;
         end else begin
            rem_re_in[k] = rem_re_ff[k];
         end
         if (CW'(rem_im_ff[k]) >= dsh) begin
            rem_im_in[k] = RW'(CW'(rem_im_ff[k]) - dsh);
            q_im_in[k][W-1-k] = 1'b1;
         end else begin
            rem_im_in[k] = rem_im_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= in_valid;
         for (int k = 0; k < NS; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end
      if (adv) begin
         rem_re_ff[0] <= n_re_sh;
         rem_im_ff[0] <= n_im_sh;
         q_re_ff[0]   <= '0;
         q_im_ff[0]   <= '0;
         den_ff[0]    <= in_den;
         ovf_re_ff[0] <= CW'(n_re_sh) >= den_top;
         ovf_im_ff[0] <= CW'(n_im_sh) >= den_top;
         side_ff[0]   <= in_side;
         for (int k = 0; k < NS; k++) begin
            rem_re_ff[k+1] <= rem_re_in[k];
            rem_im_ff[k+1] <= rem_im_in[k];
            q_re_ff[k+1]   <= q_re_in[k];
            q_im_ff[k+1]   <= q_im_in[k];
            den_ff[k+1]    <= den_ff[k];
            ovf_re_ff[k+1] <= ovf_re_ff[k];
            ovf_im_ff[k+1] <= ovf_im_ff[k];
            side_ff[k+1]   <= side_ff[k];
         end
      end
   end

   assign out_valid  = valid_ff[NS];
   assign out_q_re   = q_re_ff[NS];
   assign out_q_im   = q_im_ff[NS];
   assign out_ovf_re = ovf_re_ff[NS];
   assign out_ovf_im = ovf_im_ff[NS];
   assign out_side   = side_ff[NS];

endmodule

// ===== rtl/complex_arith_unit.sv =====
// complex arithmetic unit top level: front end, divider and result register
// depends on cau_pkg, cau_front, cau_div
//
//   channel   ports                                       direction
//   req       req_valid req_stall req_operation req_a_*   in
//             req_b_*
//   rsp       rsp_valid rsp_stall rsp_res_re rsp_res_im   out
//             rsp_div_by_zero rsp_saturated
//
// one request per cycle unless a held result stalls the pipeline; every
// operation passes through the front end, the divider's chain of one
// quotient bit per stage and the result register.
// reset clears the valid bits of every stage and of the result register.
// a held result under rsp_stall freezes the whole pipeline, and req_stall
// rises in the same cycle.
module complex_arith_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_operation,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_a_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_a_im,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_b_re,
   input  logic signed [cau_pkg::DATA_WIDTH-1:0] req_b_im,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_res_re,
   output logic signed [cau_pkg::DATA_WIDTH-1:0] rsp_res_im,
   output logic                                  rsp_div_by_zero,
   output logic                                  rsp_saturated
);

   localparam int W = cau_pkg::DATA_WIDTH;

   logic                      adv;
   logic                      f_valid;
   logic [cau_pkg::MAG_W-1:0] f_num_re, f_num_im, f_den;
   cau_pkg::side_type         f_side;
   logic                      d_valid;
   logic [W-1:0]              d_q_re, d_q_im;
   logic                      d_ovf_re, d_ovf_im;
   cau_pkg::side_type         d_side;

   logic                      rsp_valid_ff;
   logic signed [W-1:0]       res_re_ff, res_im_ff, res_re_in, res_im_in;
   logic                      dz_ff, sat_ff, dz_in, sat_in;

   // pipeline moves unless a result is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   cau_front u_front (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (req_valid),
      .in_op      (req_operation),
      .in_a_re    (req_a_re),
      .in_a_im    (req_a_im),
      .in_b_re    (req_b_re),
      .in_b_im    (req_b_im),
      .out_valid  (f_valid),
      .out_num_re (f_num_re),
      .out_num_im (f_num_im),
      .out_den    (f_den),
      .out_side   (f_side)
   );

   cau_div u_div (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (f_valid),
      .in_num_re  (f_num_re),
      .in_num_im  (f_num_im),
      .in_den     (f_den),
      .in_side    (f_side),
      .out_valid  (d_valid),
      .out_q_re   (d_q_re),
      .out_q_im   (d_q_im),
      .out_ovf_re (d_ovf_re),
      .out_ovf_im (d_ovf_im),
      .out_side   (d_side)
   );

   // sign and clip the quotients, or pass the other results through
   always_comb begin
      logic hit_re, hit_im;
      hit_re = 1'b0;
      hit_im = 1'b0;
      if (d_side.neg_re) begin
         hit_re    = d_ovf_re || (d_q_re > cau_pkg::NEG_MAG);
         res_re_in = hit_re ? $signed(cau_pkg::NEG_MAG) : $signed(~d_q_re + W'(1));
      end else begin
         hit_re    = d_ovf_re || (d_q_re > cau_pkg::POS_MAG);
         res_re_in = hit_re ? $signed(cau_pkg::POS_MAG) : $signed(d_q_re);
      end
      if (d_side.neg_im) begin
         hit_im    = d_ovf_im || (d_q_im > cau_pkg::NEG_MAG);
         res_im_in = hit_im ? $signed(cau_pkg::NEG_MAG) : $signed(~d_q_im + W'(1));
      end else begin
         hit_im    = d_ovf_im || (d_q_im > cau_pkg::POS_MAG);
         res_im_in = hit_im ? $signed(cau_pkg::POS_MAG) : $signed(d_q_im);
      end
      sat_in = hit_re | hit_im;
      dz_in  = 1'b0;
      if (!d_side.is_div) begin
         res_re_in = d_side.res_re;
         res_im_in = d_side.res_im;
         sat_in    = d_side.sat;
      end else if (d_side.dz) begin
         res_re_in = '0;
         res_im_in = '0;
         sat_in    = 1'b0;
         dz_in     = 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid;
      end
      if (adv) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         dz_ff     <= dz_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_re      = res_re_ff;
   assign rsp_res_im      = res_im_ff;
   assign rsp_div_by_zero = dz_ff;
   assign rsp_saturated   = sat_ff;

endmodule

// ===== test/complex_arith_unit_test.sv =====
`timescale 1ns / 1ps
// self-checking test of complex_arith_unit: directed and random requests
// depends on cau_pkg and the complex_arith_unit rtl
module complex_arith_unit_test;

   localparam int DW = cau_pkg::DATA_WIDTH;
   localparam int FB = cau_pkg::FRAC_BITS;
   localparam longint POS_LIM = (longint'(1) <<< (DW - 1)) - 1;
   localparam longint NEG_LIM = -(longint'(1) <<< (DW - 1));
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic                 dz;
      logic                 sat;
   } cplx_result_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [1:0] req_operation;
   logic signed [DW-1:0] req_a_re, req_a_im, req_b_re, req_b_im;
   logic rsp_valid, rsp_stall;
   logic signed [DW-1:0] rsp_res_re, rsp_res_im;
   logic rsp_div_by_zero, rsp_saturated;

   cplx_result_type expected_q[$];
   int mismatches = 0;
   int results_seen = 0;
   int requests_sent = 0;
   int op_count[4];
   int cycle_count = 0;

   complex_arith_unit dut (.*);

   // clock and cycle watchdog
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("complex_arith_unit regression: fail");
         $finish;
      end
   end

   // clip a wide value to the data range
   function automatic longint clamp(input longint v, inout logic sat);
      longint r;
      r = v;
      if (v > POS_LIM) begin
         r = POS_LIM;
         sat = 1'b1;
      end else if (v < NEG_LIM) begin
         r = NEG_LIM;
         sat = 1'b1;
      end
      return r;
   endfunction

   // floor shift of an exact product sum
   function automatic longint floor_shift(input longint v);
      return v >>> FB;
   endfunction

   // quotient truncated toward zero, scaled by fraction bits
   function automatic longint trunc_div(input longint num, input longint den);
      logic neg;
      longint mag, q;
      neg = num < 0;
      mag = neg ? -num : num;
      q = (mag <<< FB) / den;
      return neg ? -q : q;
   endfunction

   // predicted result of one complex operation
   function automatic cplx_result_type complex_result(input logic [1:0] op,
         input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
         input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
      cplx_result_type r;
      logic sat;
      longint lar, lai, lbr, lbi, den, vre, vim;
      sat = 1'b0;
      lar = ar;
      lai = ai;
      lbr = br;
      lbi = bi;
      r.dz = 1'b0;
      vre = 0;
      vim = 0;
      case (op)
         cau_pkg::OP_ADD: begin
            vre = lar + lbr;
            vim = lai + lbi;
         end
         cau_pkg::OP_SUB: begin
            vre = lar - lbr;
            vim = lai - lbi;
         end
         cau_pkg::OP_MUL: begin
            vre = floor_shift(lar * lbr - lai * lbi);
            vim = floor_shift(lar * lbi + lai * lbr);
         end
         default: begin
            den = lbr * lbr + lbi * lbi;
            if (den == 0) begin
               r.dz = 1'b1;
            end else begin
               vre = trunc_div(lar * lbr + lai * lbi, den);
               vim = trunc_div(lai * lbr - lar * lbi, den);
            end
         end
      endcase
      r.re = DW'(clamp(vre, sat));
      r.im = DW'(clamp(vim, sat));
      r.sat = sat;
      return r;
   endfunction

   // send one request with a random gap ahead of it
   task automatic send_request(input logic [1:0] op,
         input logic signed [DW-1:0] ar, input logic signed [DW-1:0] ai,
         input logic signed [DW-1:0] br, input logic signed [DW-1:0] bi);
      int gap;
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      expected_q.push_back(complex_result(op, ar, ai, br, bi));
      requests_sent++;
      op_count[op]++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic end_requests();
      req_valid <= 1'b0;
   endtask

   // result stall: random hold per result, with stall-free stretches
   initial begin
      int hold;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         hold = $urandom_range(0, 3);
         if ((cycle_count / 500) % 3 == 2) hold = 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   // result check against the oldest expectation
   always @(posedge clock) begin
      cplx_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result re=%0d im=%0d",
               rsp_res_re, rsp_res_im);
         end else begin
            want = expected_q.pop_front();
            if (rsp_res_re !== want.re || rsp_res_im !== want.im ||
                  rsp_div_by_zero !== want.dz || rsp_saturated !== want.sat) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected re=%0d im=%0d dz=%b sat=%b, %s",
                     want.re, want.im, want.dz, want.sat,
                     $sformatf("got re=%0d im=%0d dz=%b sat=%b", rsp_res_re,
                        rsp_res_im, rsp_div_by_zero, rsp_saturated));
            end
         end
      end
   end

   function automatic logic signed [DW-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return DW'(NEG_LIM);
         1: return DW'(POS_LIM);
         2: return DW'($urandom_range(0, 1023)) - DW'(512);
         3: return '0;
         default: return DW'($urandom());
      endcase
   endfunction

   // extremes, every operation, overflow and divide by zero
   task automatic test_directed();
      logic signed [DW-1:0] mx, mn;
      mx = DW'(POS_LIM);
      mn = DW'(NEG_LIM);
      send_request(cau_pkg::OP_ADD, 16'sh0100, 16'sh0200, 16'sh0300, -16'sh0100);
      send_request(cau_pkg::OP_ADD, mx, mn, mx, mn);
      send_request(cau_pkg::OP_ADD, mx, mn, mn, mx);
      send_request(cau_pkg::OP_SUB, mx, mn, mn, mx);
      send_request(cau_pkg::OP_SUB, 16'sh0000, 16'sh0000, mn, mn);
      send_request(cau_pkg::OP_SUB, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100);
      send_request(cau_pkg::OP_MUL, 16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400);
      send_request(cau_pkg::OP_MUL, mx, mx, mx, mx);
      send_request(cau_pkg::OP_MUL, mn, mn, mn, mn);
      send_request(cau_pkg::OP_MUL, mn, mx, mx, mn);
      send_request(cau_pkg::OP_MUL, -16'sh0001, 16'sh0000, 16'sh0001, 16'sh0000);
      send_request(cau_pkg::OP_MUL, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
      send_request(cau_pkg::OP_DIV, 16'sh0100, 16'sh0200, 16'sh0000, 16'sh0000);
      send_request(cau_pkg::OP_DIV, mx, mn, 16'sh0000, 16'sh0000);
      send_request(cau_pkg::OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000);
      send_request(cau_pkg::OP_DIV, mx, mx, 16'sh0001, 16'sh0000);
      send_request(cau_pkg::OP_DIV, mn, mn, 16'sh0000, 16'sh0001);
      send_request(cau_pkg::OP_DIV, mn, mn, mn, mn);
      send_request(cau_pkg::OP_DIV, 16'sh0001, -16'sh0001, mx, mn);
      send_request(cau_pkg::OP_DIV, -16'sh0300, 16'sh0100, 16'sh0200, -16'sh0300);
      send_request(cau_pkg::OP_DIV, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001);
   endtask

   // random operations and operands
   task automatic test_random(input int count);
      logic [1:0] op;
      repeat (count) begin
         op = 2'($urandom_range(0, 3));
         send_request(op, rand_word(), rand_word(), rand_word(), rand_word());
      end
   endtask

   // random divides with occasional zero divisors
   task automatic test_divide(input int count);
      logic signed [DW-1:0] br, bi;
      repeat (count) begin
         br = ($urandom_range(0, 7) == 0) ? '0 : rand_word();
         bi = ($urandom_range(0, 7) == 0) ? '0 : rand_word();
         send_request(cau_pkg::OP_DIV, rand_word(), rand_word(), br, bi);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = cau_pkg::OP_ADD;
      req_a_re = '0;
      req_a_im = '0;
      req_b_re = '0;
      req_b_im = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(1000);
      test_divide(280);
      end_requests();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DW + 10) @(posedge clock);
      $display("sent %0d requests (add %0d sub %0d mul %0d div %0d), checked %0d results",
         requests_sent, op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("complex_arith_unit regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("complex_arith_unit regression: fail");
      end
      $finish;
   end

endmodule

// ===== complex_arith_unit.f =====
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_div.sv
rtl/complex_arith_unit.sv
test/complex_arith_unit_test.sv
